// File: rtl/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg
// Shared types and constants for the block bitmap range clear engine.
// ----------------------------------------------------------------------------
package brc_pkg;

  localparam int WORD_W    = 32;
  localparam int BIT_IDX_W = 5;
  localparam int OFFSET_W  = 16;
  localparam int COUNT_W   = 17;
  localparam int TOTAL_W   = 17;
  localparam int END_W     = 18;
  localparam int WIDX_W    = 12;
  localparam int FCNT_W    = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'd65536;
  localparam logic [WORD_W-1:0]  ALL_ONES    = 32'hffff_ffff;
  localparam logic               FUNC_FREE   = 1'b0;
  localparam logic               FUNC_READ   = 1'b1;
  localparam logic               STATUS_OK   = 1'b0;
  localparam logic               STATUS_RANGE = 1'b1;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RD     = 7'b0000100,
    S_RDWAIT = 7'b0001000,
    S_CLEAR  = 7'b0010000,
    S_RMW    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  // position of one word within a range being cleared
  typedef struct packed {
    logic                 first;
    logic                 last;
    logic [BIT_IDX_W-1:0] start_pos;
    logic [BIT_IDX_W-1:0] end_pos;
  } word_span_t;

endpackage

// File: rtl/brc_mask.sv
// ----------------------------------------------------------------------------
// brc_mask
// Clear mask for one bitmap word; bit position 0 is the word's msb.
// ----------------------------------------------------------------------------
module brc_mask import brc_pkg::*; (
  input  word_span_t        span,
  output logic [WORD_W-1:0] mask
);

  logic [BIT_IDX_W-1:0] lo_pos;
  logic [BIT_IDX_W-1:0] hi_pos;

  always_comb begin
    lo_pos = span.first ? span.start_pos : '0;
    hi_pos = span.last ? span.end_pos : 5'd31;
    mask   = (ALL_ONES >> lo_pos) & (ALL_ONES << (5'd31 - hi_pos));
  end

endmodule

// File: rtl/bitmap_range_clear.sv
// ----------------------------------------------------------------------------
// bitmap_range_clear
// Block allocation bitmap with range free, word read and free-block counter.
// ----------------------------------------------------------------------------
// Items arrive on func/offset/count under in_valid/in_stall; one result per
// item leaves on status/word_value/free_count under out_valid/out_stall.
// in_stall is high whenever the sequencer is busy; only one item is in work.
// After rst the bitmap ram is filled with ones one word per cycle; no item is
// taken meanwhile, but block total writes (cfg_wr_en/cfg_wr_data) are taken
// at any time.
// A read passes S_RD (ram read) and S_RDWAIT (word captured) to S_OUT. A free
// walks the range word by word: whole words are written in S_CLEAR, the
// partial first and last words are read in S_CLEAR and written in S_RMW
// (ram read, then write); a rejected or zero-count free goes straight to
// S_OUT. The single ram port sets the pace. The result register is only
// reloaded once the previous result has been transferred, so a stalled
// receiver just holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module bitmap_range_clear import brc_pkg::*; #(
  parameter int MAX_BLOCKS = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [TOTAL_W-1:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [OFFSET_W-1:0] offset,
  input  logic [COUNT_W-1:0]  count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                status,
  output logic [WORD_W-1:0]   word_value,
  output logic [FCNT_W-1:0]   free_count
);

  localparam int BM_WORDS = (MAX_BLOCKS + 31) / 32;
  localparam int AW_RAW   = $clog2(BM_WORDS);
  localparam int AW       = (AW_RAW < 1) ? 1 : AW_RAW;
  localparam int IW       = (AW > WIDX_W) ? AW : WIDX_W;
  localparam int LIM_W    = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W    = (LIM_W > END_W) ? LIM_W : END_W;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(BM_WORDS - 1);
  localparam logic [CMP_W-1:0] MAX_LIM   = CMP_W'(MAX_BLOCKS);
  localparam logic [IW:0]      WORDS_END = (IW + 1)'(BM_WORDS);

  state_t               state;
  logic [TOTAL_W-1:0]   blk_total;
  logic [FCNT_W-1:0]    free_counter;
  logic [AW-1:0]        init_addr;
  logic [IW-1:0]        widx;
  logic [IW-1:0]        wlast;
  logic                 first_word;
  logic [BIT_IDX_W-1:0] start_pos;
  logic [BIT_IDX_W-1:0] end_pos;
  logic [COUNT_W-1:0]   cnt;
  logic                 res_status;
  logic [WORD_W-1:0]    res_word;

  logic [WORD_W-1:0]    mem [BM_WORDS];
  logic [WORD_W-1:0]    rdata;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [WORD_W-1:0]    mem_wdata;

  logic [CMP_W-1:0]     limit;
  logic [CMP_W-1:0]     range_end;
  logic [END_W-1:0]     end_blk;
  logic                 reject;
  logic                 in_xfer;
  logic                 out_free;
  logic                 at_last;
  logic                 word_in_range;
  word_span_t           span;
  logic [WORD_W-1:0]    clr_mask;
  logic [FCNT_W:0]      fc_sum;
  logic [FCNT_W-1:0]    free_counter_next;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // range check on the incoming item
  always_comb begin
    limit     = (CMP_W'(blk_total) > MAX_LIM) ? MAX_LIM : CMP_W'(blk_total);
    range_end = CMP_W'(offset) + CMP_W'(count);
    reject    = range_end > limit;
    end_blk   = END_W'(offset) + END_W'(count) - END_W'(1);
  end

  assign at_last       = (widx == wlast);
  assign word_in_range = ({1'b0, widx} < WORDS_END);

  assign span.first     = first_word;
  assign span.last      = at_last;
  assign span.start_pos = start_pos;
  assign span.end_pos   = end_pos;

  brc_mask u_mask (
    .span (span),
    .mask (clr_mask)
  );

  always_comb begin
    fc_sum            = {1'b0, free_counter} + (FCNT_W + 1)'(cnt);
    free_counter_next = fc_sum[FCNT_W] ? ALL_ONES : fc_sum[FCNT_W-1:0];
  end

  // ram port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = widx[AW-1:0];
    mem_wdata = '0;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = init_addr;
        mem_wdata = ALL_ONES;
      end
      S_RD: begin
        mem_re = word_in_range;
      end
      S_CLEAR: begin
        if (clr_mask == ALL_ONES) begin
          mem_we = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_wdata = rdata & ~clr_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      widx       <= IW'(offset[OFFSET_W-1:BIT_IDX_W]);
      wlast      <= IW'(end_blk[END_W-2:BIT_IDX_W]);
      start_pos  <= offset[BIT_IDX_W-1:0];
      end_pos    <= end_blk[BIT_IDX_W-1:0];
      cnt        <= count;
      first_word <= 1'b1;
      res_word   <= '0;
      res_status <= (func == FUNC_FREE && count != '0 && reject) ? STATUS_RANGE : STATUS_OK;
    end else begin
      if ((state == S_CLEAR && clr_mask == ALL_ONES && !at_last) ||
          (state == S_RMW && !at_last)) begin
        widx       <= widx + IW'(1);
        first_word <= 1'b0;
      end
      if (state == S_RDWAIT) begin
        res_word <= word_in_range ? rdata : '0;
      end
    end
    if (state == S_OUT && out_free) begin
      status     <= res_status;
      word_value <= res_word;
      free_count <= free_counter;
    end
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_addr    <= '0;
      blk_total    <= TOTAL_RESET;
      free_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blk_total <= cfg_wr_data;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_addr <= init_addr + AW'(1);
          if (init_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            if (func == FUNC_READ) begin
              state <= S_RD;
            end else if (count == '0 || reject) begin
              state <= S_OUT;
            end else begin
              state <= S_CLEAR;
            end
          end
        end
        S_RD: begin
          state <= S_RDWAIT;
        end
        S_RDWAIT: begin
          state <= S_OUT;
        end
        S_CLEAR: begin
          if (clr_mask != ALL_ONES) begin
            state <= S_RMW;
          end else if (at_last) begin
            free_counter <= free_counter_next;
            state        <= S_OUT;
          end
        end
        S_RMW: begin
          if (at_last) begin
            free_counter <= free_counter_next;
            state        <= S_OUT;
          end else begin
            state <= S_CLEAR;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/bitmap_range_clear_tb.sv
// ----------------------------------------------------------------------------
// bitmap_range_clear_tb
// Self-checking bench for the block bitmap range clear engine. A mirror of the
// bitmap, the free-block counter and the block total setting predicts every
// result; a monitor compares each result transfer with the oldest prediction.
// Directed ranges and limits come first, then random traffic under three
// stall patterns and three block totals, then a whole-map free.
// ----------------------------------------------------------------------------
module bitmap_range_clear_tb;
  import brc_pkg::*;

  localparam int MAX_BLOCKS  = 65536;
  localparam int BM_WORDS    = (MAX_BLOCKS + 31) / 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int OFFSET_MAX  = (1 << OFFSET_W) - 1;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] word_value;
    logic [FCNT_W-1:0] free_count;
  } bitmap_result_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [TOTAL_W-1:0]  cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic [OFFSET_W-1:0] offset;
  logic [COUNT_W-1:0]  count;
  logic                out_valid;
  logic                out_stall;
  logic                status;
  logic [WORD_W-1:0]   word_value;
  logic [FCNT_W-1:0]   free_count;

  // mirror of the block's state
  logic [WORD_W-1:0]  bitmap_mirror [0:BM_WORDS-1];
  logic [FCNT_W-1:0]  freed_blocks;
  logic [TOTAL_W-1:0] total_setting;

  bitmap_result_t pending_results [$];
  bitmap_result_t oldest_result;

  int send_idle_pct = 9;
  int recv_idle_pct = 56;
  int mismatches    = 0;
  int results_seen  = 0;
  int cycle_count   = 0;
  int n_reads       = 0;
  int n_frees       = 0;
  int n_rejects     = 0;
  int n_empty       = 0;

  bitmap_range_clear #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .offset      (offset),
    .count       (count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .word_value  (word_value),
    .free_count  (free_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver backpressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  function automatic bitmap_result_t predict_bitmap_item(input logic f,
                                                         input logic [OFFSET_W-1:0] off,
                                                         input logic [COUNT_W-1:0] cnt);
    bitmap_result_t   r;
    int unsigned      lim;
    int unsigned      b;
    int unsigned      left;
    int unsigned      w;
    int unsigned      s;
    int unsigned      n;
    logic [WORD_W-1:0] mask;
    longint unsigned  sum;
    r.status     = STATUS_OK;
    r.word_value = '0;
    if (f == FUNC_READ) begin
      w = off / 32;
      if (w < BM_WORDS) r.word_value = bitmap_mirror[w];
    end else if (cnt != 0) begin
      lim = 32'(total_setting);
      if (lim > MAX_BLOCKS) lim = MAX_BLOCKS;
      if (int'(off) + int'(cnt) > lim) begin
        r.status = STATUS_RANGE;
      end else begin
        b    = 32'(off);
        left = 32'(cnt);
        // first block of a word sits in its msb
        while (left != 0) begin
          w = b / 32;
          s = b % 32;
          n = 32 - s;
          if (n > left) n = left;
          mask = (n == 32) ? ALL_ONES : (((32'd1 << n) - 32'd1) << (32 - s - n));
          if (w < BM_WORDS) bitmap_mirror[w] = bitmap_mirror[w] & ~mask;
          b    = b + n;
          left = left - n;
        end
        sum = longint'(freed_blocks) + longint'(cnt);
        freed_blocks = (sum > longint'(ALL_ONES)) ? ALL_ONES : sum[31:0];
      end
    end
    r.free_count = freed_blocks;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d, %s: got %h expected %h", results_seen, what, got,
             want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, free_count", free_count, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (status !== oldest_result.status)
          report_mismatch("status", 32'(status), 32'(oldest_result.status));
        if (word_value !== oldest_result.word_value)
          report_mismatch("word_value", word_value, oldest_result.word_value);
        if (free_count !== oldest_result.free_count)
          report_mismatch("free_count", free_count, oldest_result.free_count);
      end
      results_seen++;
    end
  end

  // one input transfer; valid stays up from one item to the next unless idling
  task automatic send_item(input logic f, input logic [OFFSET_W-1:0] off,
                           input logic [COUNT_W-1:0] cnt);
    bitmap_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    offset   <= off;
    count    <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_bitmap_item(f, off, cnt);
    pending_results.push_back(r);
    if (f == FUNC_READ) n_reads++;
    else if (r.status == STATUS_RANGE) n_rejects++;
    else if (cnt == 0) n_empty++;
    else n_frees++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_total(input logic [TOTAL_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    total_setting = value;
  endtask

  task automatic test_directed_ranges();
    send_item(FUNC_READ, 16'd0, 17'd0);
    send_item(FUNC_FREE, 16'd123, 17'd0);
    send_item(FUNC_FREE, 16'd0, 17'd1);
    send_item(FUNC_READ, 16'd0, 17'h1ffff);
    send_item(FUNC_FREE, 16'd31, 17'd1);
    send_item(FUNC_FREE, 16'd40, 17'd8);
    // crosses a word boundary
    send_item(FUNC_FREE, 16'd60, 17'd10);
    send_item(FUNC_FREE, 16'd96, 17'd32);
    // partial, whole words, partial
    send_item(FUNC_FREE, 16'd200, 17'd200);
    send_item(FUNC_READ, 16'd32, 17'd0);
    send_item(FUNC_READ, 16'd64, 17'd0);
    send_item(FUNC_READ, 16'd127, 17'd0);
    send_item(FUNC_READ, 16'd224, 17'd0);
    send_item(FUNC_READ, 16'd399, 17'd0);
    send_item(FUNC_FREE, 16'hffff, 17'd1);
    send_item(FUNC_READ, 16'hffff, 17'd0);
    send_item(FUNC_FREE, 16'hffff, 17'd2);
    send_item(FUNC_FREE, 16'd0, 17'h1ffff);
    send_item(FUNC_FREE, 16'hffff, 17'h1ffff);
    send_item(FUNC_FREE, 16'd1, 17'd65536);
    // ends exactly at the limit
    send_item(FUNC_FREE, 16'd65000, 17'd536);
    send_item(FUNC_READ, 16'd65000, 17'd0);
    send_item(FUNC_READ, 16'd65504, 17'd0);
  endtask

  task automatic test_total_setting();
    wait_drained();
    write_total(17'd0);
    send_item(FUNC_FREE, 16'd0, 17'd1);
    send_item(FUNC_FREE, 16'd500, 17'd0);
    send_item(FUNC_READ, 16'd500, 17'd0);
    wait_drained();
    write_total(17'd1000);
    send_item(FUNC_FREE, 16'd990, 17'd10);
    send_item(FUNC_FREE, 16'd990, 17'd11);
    send_item(FUNC_FREE, 16'd999, 17'd1);
    send_item(FUNC_FREE, 16'd1000, 17'd1);
    send_item(FUNC_READ, 16'd992, 17'd0);
    wait_drained();
    // above the storage size, the limit stays at the storage size
    write_total(17'h1ffff);
    send_item(FUNC_FREE, 16'd65530, 17'd6);
    send_item(FUNC_FREE, 16'd0, 17'd65537);
    send_item(FUNC_FREE, 16'hffff, 17'd2);
    send_item(FUNC_READ, 16'd65530, 17'd0);
  endtask

  task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct,
                                     input logic [TOTAL_W-1:0] total);
    int unsigned         lim;
    int unsigned         pick;
    int unsigned         off_i;
    logic [OFFSET_W-1:0] recent_off;
    logic [OFFSET_W-1:0] off;
    logic [COUNT_W-1:0]  cnt;
    wait_drained();
    write_total(total);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    lim = (32'(total) > MAX_BLOCKS) ? MAX_BLOCKS : 32'(total);
    recent_off = '0;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      off  = OFFSET_W'($urandom);
      if (pick < 30) begin
        // half the reads look at words just freed
        if (pick < 15) off = recent_off + OFFSET_W'($urandom_range(0, 63));
        send_item(FUNC_READ, off, COUNT_W'($urandom));
      end else if (pick < 33) begin
        send_item(FUNC_FREE, off, '0);
      end else begin
        if (pick < 41) begin
          off_i = (lim > 40) ? lim - $urandom_range(0, 40) : $urandom_range(0, lim);
          if (off_i > OFFSET_MAX) off_i = OFFSET_MAX;
          off = OFFSET_W'(off_i);
          cnt = COUNT_W'($urandom_range(1, 80));
        end else if (pick < 44) begin
          cnt = COUNT_W'($urandom);
        end else if (pick < 46) begin
          cnt = COUNT_W'($urandom_range(300, 3000));
        end else if (pick < 86) begin
          cnt = COUNT_W'($urandom_range(1, 40));
        end else begin
          cnt = COUNT_W'($urandom_range(41, 300));
        end
        recent_off = off;
        send_item(FUNC_FREE, off, cnt);
      end
    end
  endtask

  task automatic test_full_range_free();
    wait_drained();
    write_total(TOTAL_RESET);
    send_item(FUNC_FREE, 16'd0, 17'd65536);
    send_item(FUNC_READ, 16'd0, 17'd0);
    send_item(FUNC_READ, 16'd32768, 17'd0);
    send_item(FUNC_READ, 16'hffff, 17'd0);
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    func        = FUNC_FREE;
    offset      = '0;
    count       = '0;
    for (int i = 0; i < BM_WORDS; i++) bitmap_mirror[i] = ALL_ONES;
    freed_blocks  = '0;
    total_setting = TOTAL_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_ranges();
    test_total_setting();
    test_random_traffic(380, 9, 56, 17'($urandom_range(20000, 65536)));
    test_random_traffic(380, 56, 9, TOTAL_RESET);
    test_random_traffic(380, 0, 0, 17'h1ffff);
    test_full_range_free();

    wait_drained();
    repeat (16) @(posedge clk);
    $display("%0d results checked: %0d frees taken, %0d rejected, %0d empty, %0d reads",
             results_seen, n_frees, n_rejects, n_empty, n_reads);
    $display("free counter ended at %0d after %0d cycles, %0d mismatches", freed_blocks,
             cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
